// ===== rtl/core/vdtm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the vector distance threshold match core.
// Used by vdtm_ctrl, vdtm_dpath and vector_distance_threshold_match_core.
package vdtm_pkg;

    localparam int SUM_W   = 48;
    localparam int CFG_W   = 48;
    localparam int CNT_W   = 7;
    localparam int TAG_W   = 16;
    localparam int VAL_W   = 16;
    localparam int IDX_W   = 6;

    localparam logic [CNT_W-1:0] VLEN_RST = 7'd64;
    localparam logic [CNT_W-1:0] RCNT_RST = 7'd64;

    typedef enum logic [1:0] {
        REQ_LOAD_REF = 2'd0,
        REQ_LOAD_QRY = 2'd1,
        REQ_COMPARE  = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        CFG_EPS  = 2'd0,
        CFG_VLEN = 2'd1,
        CFG_RCNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [IDX_W-1:0]        vector_index;
        logic [IDX_W-1:0]        element_index;
        logic signed [VAL_W-1:0] value;
        logic [TAG_W-1:0]        row_tag;
        logic [TAG_W-1:0]        column_base;
    } t_in_req;

    typedef struct packed {
        logic [TAG_W-1:0] result_row;
        logic [TAG_W-1:0] column_index;
        logic             match;
        logic             last;
    } t_out_res;

    typedef struct packed {
        logic             accept;
        logic             start;
        logic             issue;
        logic             emit;
        logic             last;
        logic [CNT_W-1:0] ref_idx;
        logic [CNT_W-1:0] elem_idx;
    } t_vdtm_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_vdtm_sts;

endpackage

// ===== rtl/core/vector_distance_threshold_match_core.sv =====
`timescale 1ns / 1ps
// Top level of the squared-distance threshold match core: config registers and wiring.
// Depends on vdtm_pkg, vdtm_ctrl and vdtm_dpath.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in  (vdtm_pkg::t_in_req)
//   out      output     o_out_valid / i_out_stall o_out (vdtm_pkg::t_out_res)
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// A load request leaves the sequencer idle. A compare walks n references of len
// elements, one at a time, through the one shared square-accumulate unit
// and the single read port of the reference memory; o_in_stall stays high
// throughout. A stalled output only holds the sequencer at the next result.
// Reset is synchronous; memories are not cleared.
module vector_distance_threshold_match_core #(
    parameter int MAX_REFS   = 64,
    parameter int MAX_LEN    = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  vdtm_pkg::t_in_req              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output vdtm_pkg::t_out_res             o_out,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [vdtm_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [vdtm_pkg::SUM_W-1:0] r_eps;
    logic [vdtm_pkg::CNT_W-1:0] r_vec_len;
    logic [vdtm_pkg::CNT_W-1:0] r_ref_cnt;
    logic [vdtm_pkg::CNT_W-1:0] w_len_eff;
    logic [vdtm_pkg::CNT_W-1:0] w_cnt_eff;
    vdtm_pkg::t_vdtm_cmd        w_cmd;
    vdtm_pkg::t_vdtm_sts        w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps     <= '0;
            r_vec_len <= vdtm_pkg::VLEN_RST;
            r_ref_cnt <= vdtm_pkg::RCNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vdtm_pkg::CFG_EPS:  r_eps     <= i_cfg_data[vdtm_pkg::SUM_W-1:0];
                vdtm_pkg::CFG_VLEN: r_vec_len <= i_cfg_data[vdtm_pkg::CNT_W-1:0];
                vdtm_pkg::CFG_RCNT: r_ref_cnt <= i_cfg_data[vdtm_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_len_eff = (9'(r_vec_len) > 9'(MAX_LEN)) ? 7'(MAX_LEN) : r_vec_len;
    assign w_cnt_eff = (9'(r_ref_cnt) > 9'(MAX_REFS)) ? 7'(MAX_REFS) : r_ref_cnt;

    vdtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in.req_type),
        .i_ref_cnt  (w_cnt_eff),
        .i_vec_len  (w_len_eff),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    vdtm_dpath #(
        .MAX_REFS   (MAX_REFS),
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_eps       (r_eps),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    a_accept_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !w_sts.pipe_busy)
        else $error("request accepted while accumulate pipe busy");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out_valid)
        else $error("emitted result not presented");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.start, w_cmd.issue, w_cmd.emit}))
        else $error("conflicting datapath commands");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_cmd.last) |=> !o_in_stall)
        else $error("sequencer did not return to idle after last result");
`endif

endmodule

// ===== rtl/core/vdtm_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the match core: accepts requests, walks references and elements.
// Depends on vdtm_pkg; drives vdtm_dpath through command and status structs.
module vdtm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [1:0]                     i_req_type,
    input  logic [vdtm_pkg::CNT_W-1:0]     i_ref_cnt,
    input  logic [vdtm_pkg::CNT_W-1:0]     i_vec_len,
    input  vdtm_pkg::t_vdtm_sts            i_sts,
    output vdtm_pkg::t_vdtm_cmd            o_cmd,
    output logic                           o_in_stall
);

    vdtm_pkg::t_state              r_state, n_state;
    logic [vdtm_pkg::CNT_W-1:0]    r_ref, n_ref;
    logic [vdtm_pkg::CNT_W-1:0]    r_elem, n_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdtm_pkg::ST_IDLE;
            r_ref   <= '0;
            r_elem  <= '0;
        end else begin
            r_state <= n_state;
            r_ref   <= n_ref;
            r_elem  <= n_elem;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_ref          = r_ref;
        n_elem         = r_elem;
        o_cmd          = '0;
        o_cmd.ref_idx  = r_ref;
        o_cmd.elem_idx = r_elem;
        o_cmd.last     = ((r_ref + 7'd1) == i_ref_cnt);
        o_in_stall     = 1'b1;
        unique case (r_state)
            vdtm_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_req_type == vdtm_pkg::REQ_COMPARE && i_ref_cnt != '0) begin
                        o_cmd.start = 1'b1;
                        n_ref       = '0;
                        n_elem      = '0;
                        n_state     = vdtm_pkg::ST_RUN;
                    end
                end
            end
            vdtm_pkg::ST_RUN: begin
                if (r_elem < i_vec_len) begin
                    o_cmd.issue = 1'b1;
                    n_elem      = r_elem + 7'd1;
                end else begin
                    n_state = vdtm_pkg::ST_DRAIN;
                end
            end
            vdtm_pkg::ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = vdtm_pkg::ST_EMIT;
                end
            end
            vdtm_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (o_cmd.last) begin
                        n_state = vdtm_pkg::ST_IDLE;
                    end else begin
                        n_ref   = r_ref + 7'd1;
                        n_elem  = '0;
                        n_state = vdtm_pkg::ST_RUN;
                    end
                end
            end
            default: begin
                n_state = vdtm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/vdtm_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: reference and query memories, square-accumulate pipe, result register.
// Depends on vdtm_pkg; controlled by vdtm_ctrl.
module vdtm_dpath #(
    parameter int MAX_REFS   = 64,
    parameter int MAX_LEN    = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vdtm_pkg::t_in_req                 i_in,
    input  vdtm_pkg::t_vdtm_cmd               i_cmd,
    input  logic [vdtm_pkg::SUM_W-1:0]        i_eps,
    input  logic                              i_out_stall,
    output vdtm_pkg::t_vdtm_sts               o_sts,
    output logic                              o_out_valid,
    output vdtm_pkg::t_out_res                o_out
);

    localparam int SW    = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int LW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int RW    = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int DEPTH = MAX_REFS * (1 << LW);
    localparam int SQW   = 2 * (SW + 1);
    localparam int AW    = vdtm_pkg::SUM_W;

    logic [SW-1:0]  r_ref_mem [DEPTH];
    logic [SW-1:0]  r_qry_mem [MAX_LEN];
    logic [SW-1:0]  r_ref_rd, r_qry_rd;
    logic           r_rd_vld, r_sq_vld;
    logic [SQW-1:0] r_sq;
    logic [AW-1:0]  r_acc;
    logic [15:0]    r_row, r_base;
    logic           r_out_vld;
    vdtm_pkg::t_out_res r_out;

    logic           w_ld_ref, w_ld_qry;
    logic [SW-1:0]  w_val;
    logic [RW+LW-1:0] w_wr_addr, w_rd_addr;
    logic [SW:0]    w_diff, w_mag;
    logic [SQW-1:0] w_sq;
    logic [AW:0]    w_acc_sum;
    logic [AW-1:0]  w_acc_sat;

    assign w_val    = i_in.value[SW-1:0];
    assign w_ld_ref = i_cmd.accept && (i_in.req_type == vdtm_pkg::REQ_LOAD_REF)
                      && (9'(i_in.vector_index) < 9'(MAX_REFS))
                      && (9'(i_in.element_index) < 9'(MAX_LEN));
    assign w_ld_qry = i_cmd.accept && (i_in.req_type == vdtm_pkg::REQ_LOAD_QRY)
                      && (9'(i_in.element_index) < 9'(MAX_LEN));
    assign w_wr_addr = {RW'(i_in.vector_index), LW'(i_in.element_index)};
    assign w_rd_addr = {i_cmd.ref_idx[RW-1:0], LW'(i_cmd.elem_idx)};

    always_ff @(posedge i_clk) begin
        if (w_ld_ref) begin
            r_ref_mem[w_wr_addr] <= w_val;
        end
        if (w_ld_qry) begin
            r_qry_mem[LW'(i_in.element_index)] <= w_val;
        end
        if (i_cmd.issue) begin
            r_ref_rd <= r_ref_mem[w_rd_addr];
            r_qry_rd <= r_qry_mem[LW'(i_cmd.elem_idx)];
        end
    end

    assign w_diff    = {r_qry_rd[SW-1], r_qry_rd} - {r_ref_rd[SW-1], r_ref_rd};
    assign w_mag     = w_diff[SW] ? (~w_diff + (SW+1)'(1)) : w_diff;
    assign w_sq      = SQW'(w_mag) * SQW'(w_mag);
    assign w_acc_sum = {1'b0, r_acc} + (AW+1)'(r_sq);
    assign w_acc_sat = w_acc_sum[AW] ? {AW{1'b1}} : w_acc_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_sq_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            r_sq_vld <= r_rd_vld;
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_sq <= w_sq;
        end
        if (i_cmd.start || i_cmd.emit) begin
            r_acc <= '0;
        end else if (r_sq_vld) begin
            r_acc <= w_acc_sat;
        end
        if (i_cmd.start) begin
            r_row  <= i_in.row_tag;
            r_base <= i_in.column_base;
        end
        if (i_cmd.emit) begin
            r_out.result_row   <= r_row;
            r_out.column_index <= r_base + 16'(i_cmd.ref_idx);
            r_out.match        <= (r_acc <= i_eps);
            r_out.last         <= i_cmd.last;
        end
    end

    assign o_sts.pipe_busy = r_rd_vld || r_sq_vld;
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid     = r_out_vld;
    assign o_out           = r_out;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for vector_distance_threshold_match_core: loads references and queries,
// compares them under varied sizes and thresholds, and scores every result in order.
// Depends on vdtm_pkg and the core RTL.
module tb;

    localparam int MAX_REFS      = 64;
    localparam int MAX_LEN       = 64;
    localparam int ITEM_TARGET   = 210;
    localparam int SETTLE_CYCLES = 2 * (MAX_LEN + 4);
    localparam int CYCLE_LIMIT   = 5000000;
    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam logic [63:0] SUM_MAX    = (64'd1 << vdtm_pkg::SUM_W) - 64'd1;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    class match_board;
        logic signed [vdtm_pkg::VAL_W-1:0] ref_mem [MAX_REFS*MAX_LEN];
        logic signed [vdtm_pkg::VAL_W-1:0] qry_mem [MAX_LEN];
        logic [vdtm_pkg::SUM_W-1:0]        eps;
        logic [vdtm_pkg::CNT_W-1:0]        vlen;
        logic [vdtm_pkg::CNT_W-1:0]        rcnt;
        vdtm_pkg::t_out_res                match_queue [$];
        int                                errors;
        int                                checked;
        int                                matched;

        function new();
            eps     = '0;
            vlen    = vdtm_pkg::VLEN_RST;
            rcnt    = vdtm_pkg::RCNT_RST;
            errors  = 0;
            checked = 0;
            matched = 0;
        endfunction

        function void note_config(input vdtm_pkg::t_cfg_idx idx,
                                  input logic [vdtm_pkg::CFG_W-1:0] data);
            case (idx)
                vdtm_pkg::CFG_EPS:  eps  = data[vdtm_pkg::SUM_W-1:0];
                vdtm_pkg::CFG_VLEN: vlen = data[vdtm_pkg::CNT_W-1:0];
                vdtm_pkg::CFG_RCNT: rcnt = data[vdtm_pkg::CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [vdtm_pkg::SUM_W-1:0] squared_distance(input int r, input int len);
            logic [63:0] sum;
            longint      d;
            longint      sq;
            sum = '0;
            for (int i = 0; i < len; i++) begin
                d  = longint'(qry_mem[i]) - longint'(ref_mem[r * MAX_LEN + i]);
                sq = d * d;
                if (sq > SUM_MAX - sum) sum = SUM_MAX;
                else sum = sum + sq;
            end
            return sum[vdtm_pkg::SUM_W-1:0];
        endfunction

        function void note_request(input vdtm_pkg::t_in_req req);
            vdtm_pkg::t_out_res res;
            int                 n;
            int                 len;
            case (req.req_type)
                vdtm_pkg::REQ_LOAD_REF: begin
                    ref_mem[int'(req.vector_index) * MAX_LEN + int'(req.element_index)] =
                        req.value;
                end
                vdtm_pkg::REQ_LOAD_QRY: begin
                    qry_mem[req.element_index] = req.value;
                end
                vdtm_pkg::REQ_COMPARE: begin
                    n   = (rcnt > MAX_REFS) ? MAX_REFS : int'(rcnt);
                    len = (vlen > MAX_LEN) ? MAX_LEN : int'(vlen);
                    for (int r = 0; r < n; r++) begin
                        res.result_row   = req.row_tag;
                        res.column_index = req.column_base + vdtm_pkg::TAG_W'(r);
                        res.match        = (squared_distance(r, len) <= eps);
                        res.last         = (r == n - 1);
                        match_queue.push_back(res);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(input vdtm_pkg::t_out_res got);
            vdtm_pkg::t_out_res want;
            if (match_queue.size() == 0) begin
                $error("result row %0h column %0h arrived with nothing pending",
                       got.result_row, got.column_index);
                errors++;
                return;
            end
            want = match_queue.pop_front();
            checked++;
            if (got.match === 1'b1) matched++;
            if (got.result_row !== want.result_row) begin
                $error("result_row: expected %0h, got %0h", want.result_row, got.result_row);
                errors++;
            end
            if (got.column_index !== want.column_index) begin
                $error("column_index: expected %0h, got %0h",
                       want.column_index, got.column_index);
                errors++;
            end
            if (got.match !== want.match) begin
                $error("match: expected %0b, got %0b", want.match, got.match);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    vdtm_pkg::t_in_req            i_in        = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    vdtm_pkg::t_out_res           o_out;
    logic                         i_cfg_we    = 1'b0;
    logic [1:0]                   i_cfg_index = '0;
    logic [vdtm_pkg::CFG_W-1:0]   i_cfg_data  = '0;

    match_board  board;
    bit          ref_loaded [MAX_REFS*MAX_LEN];
    bit          qry_loaded [MAX_LEN];
    int          burst_left    = 0;
    int          item_count    = 0;
    int          compare_count = 0;
    int          reg_writes    = 0;
    int unsigned cycle_count   = 0;
    t_stall_mode stall_mode    = STALL_NONE;
    int          stall_left    = 0;

    vector_distance_threshold_match_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_out);
        end
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_left = $urandom_range(8, 40);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= 1'($urandom_range(0, 1));
            default:     i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic vdtm_pkg::t_in_req random_req();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(vdtm_pkg::t_in_req)-1:0];
    endfunction

    function automatic vdtm_pkg::t_in_req load_req(input logic [1:0] kind, input int vi,
                                                   input int ei,
                                                   input logic [vdtm_pkg::VAL_W-1:0] val);
        vdtm_pkg::t_in_req r;
        r               = random_req();
        r.req_type      = kind;
        r.vector_index  = vdtm_pkg::IDX_W'(vi);
        r.element_index = vdtm_pkg::IDX_W'(ei);
        r.value         = val;
        return r;
    endfunction

    function automatic logic [vdtm_pkg::VAL_W-1:0] pick_value(
        input logic [vdtm_pkg::VAL_W-1:0] near);
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return near;
            3, 4:    return near + vdtm_pkg::VAL_W'($urandom_range(0, 8))
                           - vdtm_pkg::VAL_W'(4);
            default: return vdtm_pkg::VAL_W'($urandom);
        endcase
    endfunction

    task automatic push_request(input vdtm_pkg::t_in_req req);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 8);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(req);
        burst_left--;
        if (req.req_type == vdtm_pkg::REQ_LOAD_REF)
            ref_loaded[int'(req.vector_index) * MAX_LEN + int'(req.element_index)] = 1'b1;
        else if (req.req_type == vdtm_pkg::REQ_LOAD_QRY)
            qry_loaded[req.element_index] = 1'b1;
        if (req.req_type != REQ_UNUSED) item_count++;
        if (req.req_type == vdtm_pkg::REQ_COMPARE) compare_count++;
    endtask

    task automatic write_reg(input vdtm_pkg::t_cfg_idx idx,
                             input logic [vdtm_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.note_config(idx, data);
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (board.match_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("vector_distance_threshold_match_core verification failed");
        $finish;
    end

    initial begin
        vdtm_pkg::t_in_req          r;
        vdtm_pkg::t_in_req          tmp;
        vdtm_pkg::t_in_req          load_list [$];
        logic [vdtm_pkg::VAL_W-1:0] pattern [MAX_LEN];
        logic [vdtm_pkg::SUM_W-1:0] ref_dist;
        logic [vdtm_pkg::SUM_W-1:0] eps_val;
        logic [vdtm_pkg::CNT_W-1:0] len_cfg;
        logic [vdtm_pkg::CNT_W-1:0] cnt_cfg;
        int                         eff_len;
        int                         eff_cnt;
        int                         phase;
        int                         n_cmp;
        int                         j;
        int                         tr;
        int                         te;

        board = new();
        phase = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // unused request type, all fields high
        r = '1;
        r.req_type = REQ_UNUSED;
        push_request(r);
        settle();

        // zero reference count: compare yields nothing
        write_reg(vdtm_pkg::CFG_RCNT, vdtm_pkg::CFG_W'(0));
        r = '1;
        r.req_type = vdtm_pkg::REQ_COMPARE;
        push_request(r);
        settle();

        // zero vector length: everything matches, column index wraps
        write_reg(vdtm_pkg::CFG_VLEN, vdtm_pkg::CFG_W'(0));
        write_reg(vdtm_pkg::CFG_RCNT, vdtm_pkg::CFG_W'(3));
        r = '0;
        r.req_type    = vdtm_pkg::REQ_COMPARE;
        r.column_base = 16'hFFFE;
        push_request(r);
        settle();

        // extreme values, threshold exactly at a distance, just below it and at the maximum
        write_reg(vdtm_pkg::CFG_VLEN, vdtm_pkg::CFG_W'(2));
        write_reg(vdtm_pkg::CFG_RCNT, vdtm_pkg::CFG_W'(2));
        push_request(load_req(vdtm_pkg::REQ_LOAD_REF, 0, 0, 16'h8000));
        push_request(load_req(vdtm_pkg::REQ_LOAD_REF, 0, 1, 16'h7FFF));
        push_request(load_req(vdtm_pkg::REQ_LOAD_REF, 1, 0, 16'h0000));
        push_request(load_req(vdtm_pkg::REQ_LOAD_REF, 1, 1, 16'h0000));
        push_request(load_req(vdtm_pkg::REQ_LOAD_QRY, 0, 0, 16'h7FFF));
        push_request(load_req(vdtm_pkg::REQ_LOAD_QRY, 0, 1, 16'h8000));
        settle();
        ref_dist = board.squared_distance(1, 2);
        write_reg(vdtm_pkg::CFG_EPS, vdtm_pkg::CFG_W'(ref_dist));
        r = random_req();
        r.req_type = vdtm_pkg::REQ_COMPARE;
        push_request(r);
        settle();
        write_reg(vdtm_pkg::CFG_EPS, vdtm_pkg::CFG_W'(ref_dist - 1'b1));
        r = random_req();
        r.req_type = vdtm_pkg::REQ_COMPARE;
        push_request(r);
        settle();
        write_reg(vdtm_pkg::CFG_EPS, vdtm_pkg::CFG_W'(SUM_MAX[vdtm_pkg::SUM_W-1:0]));
        r = random_req();
        r.req_type = vdtm_pkg::REQ_COMPARE;
        push_request(r);

        while (item_count < ITEM_TARGET || phase < 6) begin
            phase++;
            if (phase == 3) begin
                len_cfg = $urandom_range(0, 1) ? 7'd64
                                               : vdtm_pkg::CNT_W'($urandom_range(65, 127));
                cnt_cfg = 7'd1;
            end else if (phase == 6) begin
                len_cfg = 7'd1;
                cnt_cfg = $urandom_range(0, 1) ? 7'd64
                                               : vdtm_pkg::CNT_W'($urandom_range(65, 127));
            end else begin
                len_cfg = ($urandom_range(0, 9) == 0) ? 7'd0
                                                      : vdtm_pkg::CNT_W'($urandom_range(1, 6));
                cnt_cfg = ($urandom_range(0, 9) == 0) ? 7'd0
                                                      : vdtm_pkg::CNT_W'($urandom_range(1, 6));
            end
            settle();
            write_reg(vdtm_pkg::CFG_VLEN, vdtm_pkg::CFG_W'(len_cfg));
            write_reg(vdtm_pkg::CFG_RCNT, vdtm_pkg::CFG_W'(cnt_cfg));
            eff_len = (len_cfg > MAX_LEN) ? MAX_LEN : int'(len_cfg);
            eff_cnt = (cnt_cfg > MAX_REFS) ? MAX_REFS : int'(cnt_cfg);

            for (int e = 0; e < eff_len; e++) begin
                case ($urandom_range(0, 7))
                    0:       pattern[e] = 16'h8000;
                    1:       pattern[e] = 16'h7FFF;
                    default: pattern[e] = vdtm_pkg::VAL_W'($urandom);
                endcase
            end

            load_list.delete();
            if (eff_cnt != 0) begin
                for (int e = 0; e < eff_len; e++) begin
                    if (!qry_loaded[e] || $urandom_range(0, 1))
                        load_list.push_back(load_req(vdtm_pkg::REQ_LOAD_QRY, $urandom, e,
                            ($urandom_range(0, 3) != 0) ? pattern[e] : pick_value(pattern[e])));
                end
            end
            for (int rf = 0; rf < eff_cnt; rf++) begin
                for (int e = 0; e < eff_len; e++) begin
                    if (!ref_loaded[rf * MAX_LEN + e] || $urandom_range(0, 1))
                        load_list.push_back(load_req(vdtm_pkg::REQ_LOAD_REF, rf, e,
                                                     pick_value(pattern[e])));
                end
            end
            for (int i = load_list.size() - 1; i > 0; i--) begin
                j            = $urandom_range(0, i);
                tmp          = load_list[i];
                load_list[i] = load_list[j];
                load_list[j] = tmp;
            end
            foreach (load_list[i]) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = random_req();
                    if ($urandom_range(0, 1)) r.req_type = REQ_UNUSED;
                    else r.req_type = $urandom_range(0, 1) ? vdtm_pkg::REQ_LOAD_REF
                                                           : vdtm_pkg::REQ_LOAD_QRY;
                    push_request(r);
                end
                push_request(load_list[i]);
            end

            n_cmp = $urandom_range(1, 3);
            for (int k = 0; k < n_cmp; k++) begin
                if (k != 0 && eff_len != 0 && eff_cnt != 0) begin
                    repeat ($urandom_range(0, 3)) begin
                        tr = $urandom_range(0, eff_cnt - 1);
                        te = $urandom_range(0, eff_len - 1);
                        if ($urandom_range(0, 1))
                            push_request(load_req(vdtm_pkg::REQ_LOAD_QRY, $urandom, te,
                                                  pick_value(pattern[te])));
                        else
                            push_request(load_req(vdtm_pkg::REQ_LOAD_REF, tr, te,
                                                  pick_value(pattern[te])));
                    end
                end
                settle();
                ref_dist = '0;
                if (eff_cnt != 0 && eff_len != 0)
                    ref_dist = board.squared_distance($urandom_range(0, eff_cnt - 1), eff_len);
                case ($urandom_range(0, 5))
                    0:       eps_val = '0;
                    1:       eps_val = SUM_MAX[vdtm_pkg::SUM_W-1:0];
                    2:       eps_val = ref_dist;
                    3:       eps_val = (ref_dist == 0) ? ref_dist : ref_dist - 1'b1;
                    4:       eps_val = ref_dist + 1'b1;
                    default: eps_val = {vdtm_pkg::VAL_W'($urandom), 32'($urandom)} >>
                                       $urandom_range(0, vdtm_pkg::SUM_W - 1);
                endcase
                write_reg(vdtm_pkg::CFG_EPS, vdtm_pkg::CFG_W'(eps_val));
                r = random_req();
                r.req_type = vdtm_pkg::REQ_COMPARE;
                if ($urandom_range(0, 3) == 0)
                    r.column_base = 16'hFFFF - vdtm_pkg::TAG_W'($urandom_range(0, 3));
                push_request(r);
            end
        end

        settle();
        $display("Run drove %0d requests, %0d of them compares, over %0d register writes.",
                 item_count, compare_count, reg_writes);
        $display("Scored %0d results, %0d reported as matches.", board.checked, board.matched);
        if (board.errors == 0) begin
            $display("vector_distance_threshold_match_core verification clean");
        end else begin
            $display("vector_distance_threshold_match_core verification failed");
        end
        $finish;
    end

endmodule
